/* rtl/fism_pkg.sv */
package fism_pkg;

  localparam int unsigned TsBits       = 64;
  localparam int unsigned TypBits      = 56;
  localparam int unsigned RateBits     = 32;
  localparam int unsigned IntervalBitsDef = 40;
  localparam int unsigned CountBitsDef    = 24;
  localparam int unsigned CfgIdxBits   = 3;
  localparam int unsigned CfgDataBits  = 40;

  localparam logic [CfgIdxBits-1:0] RegWindow  = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegAbsThr  = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegRelFac  = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegGain    = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegReject  = 3'd4;

  localparam logic [39:0] WindowRst = 40'd500000000;
  localparam logic [15:0] GainRst   = 16'd3277;
  localparam logic [3:0]  RejectRst = 4'd4;

  // frames * 1e9 * 256
  localparam logic [39:0] FpsScale = 40'd256000000000;

endpackage

/* rtl/fism_divider.sv */
module fism_divider #(
  parameter int unsigned NumBits = 128,
  parameter int unsigned DenBits = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NumBits-1:0]   num_i,
  input  logic [DenBits-1:0]   den_i,
  output logic                 busy_o,
  output logic [NumBits-1:0]   quot_o
);
  localparam int unsigned CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0] quot_q, quot_d;
  logic [DenBits-1:0] rem_q, rem_d;
  logic [DenBits-1:0] den_q;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic [DenBits:0]   shifted;

  // restoring division, one quotient bit a cycle; remainder stays below den
  always_comb begin
    quot_d  = quot_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    shifted = {rem_q, quot_q[NumBits-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      cnt_d  = CntBits'(NumBits);
    end else if (cnt_q != '0) begin
      if (shifted >= {1'b0, den_q}) begin
        rem_d = DenBits'(shifted - {1'b0, den_q});
        quot_d = {quot_q[NumBits-2:0], 1'b1};
      end else begin
        rem_d = shifted[DenBits-1:0];
        quot_d = {quot_q[NumBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quot_q;
endmodule

/* rtl/frame_interval_spike_monitor_unit.sv */
// Frame interval spike monitor.
// Input channel: one 64-bit timestamp (ns) per frame start, valid/ready.
// Output channel: one result transaction per input: interval, spike flag,
// effective threshold, typical estimate and last-window statistics.
// Config channel: cfg_valid_i/cfg_ready_o with index and data; write only
// while idle. Index 0 window, 1 abs threshold, 2 relative factor,
// 3 ema gain, 4 reject ratio; other indexes are dropped.
// The gain and factor multiplies are bit-serial over the 16 coefficient
// bits (skipped when the interval is rejected or seeds the average, or
// when the relative threshold is off). A closing frame first runs two
// 128-step divisions (average, then rate) in the shared bit-serial
// divider.
// One item is in flight at a time; in_ready_o is low from acceptance until
// the result transaction is taken. The output register holds while the
// receiver stalls; the next item is accepted the cycle after it empties.
// Reset clears control, window and estimate state (not the result register) and
// loads register defaults; results restart with a fresh window on the first frame.
module frame_interval_spike_monitor_unit #(
  parameter int unsigned INTERVAL_BITS = fism_pkg::IntervalBitsDef,
  parameter int unsigned COUNT_BITS    = fism_pkg::CountBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fism_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [fism_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [63:0]                   timestamp_ns_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          interval_valid_o,
  output logic [INTERVAL_BITS-1:0]      frame_ns_o,
  output logic                          spike_o,
  output logic [INTERVAL_BITS-1:0]      threshold_ns_o,
  output logic [INTERVAL_BITS-1:0]      typical_ns_o,
  output logic                          window_closed_o,
  output logic [INTERVAL_BITS-1:0]      avg_frame_ns_o,
  output logic [31:0]                   fps_q8_o,
  output logic [INTERVAL_BITS-1:0]      window_worst_ns_o,
  output logic [COUNT_BITS-1:0]         window_spikes_o
);
  import fism_pkg::*;

  localparam logic [INTERVAL_BITS-1:0] IMax = '1;
  localparam logic [COUNT_BITS-1:0]    CMax = '1;
  localparam logic [TypBits-1:0]       TMax = '1;
  localparam int unsigned WideBits = 2 * TsBits;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StPrep  = 4'd1;
  localparam logic [3:0] StAvgGo = 4'd2;
  localparam logic [3:0] StAvgW  = 4'd3;
  localparam logic [3:0] StFpsGo = 4'd4;
  localparam logic [3:0] StFpsW  = 4'd5;
  localparam logic [3:0] StEma   = 4'd6;
  localparam logic [3:0] StEmaMul = 4'd7;
  localparam logic [3:0] StRel   = 4'd8;
  localparam logic [3:0] StRelMul = 4'd9;
  localparam logic [3:0] StFin   = 4'd10;

  // configuration
  logic [39:0] win_q, abs_q;
  logic [15:0] rel_q, gain_q;
  logic [3:0]  rej_q;

  // state
  logic                  wstart_q, have_prev_q;
  logic [TsBits-1:0]     wtime_q, prev_q, now_q;
  logic [COUNT_BITS-1:0] wframes_q, cur_spk_q, last_spk_q;
  logic [TypBits-1:0]    typ_q;
  logic [INTERVAL_BITS-1:0] cur_worst_q, last_worst_q, last_avg_q, frame_q;
  logic [RateBits-1:0]   last_rate_q;
  logic [3:0]            st_q;
  logic                  closed_q, valid_q;
  logic [TsBits-1:0]     elapsed_q;

  // serial multiplier: acc += mcand when coefficient bit set, coefficient lsb first
  logic [TypBits+16:0] acc_q;
  logic [TypBits+15:0] mcand_q;
  logic [15:0]         coef_q;
  logic [4:0]          mcnt_q;
  logic                neg_q;
  logic [TypBits+3:0]  rej_lim;
  logic [TypBits-1:0]  fx;
  logic [63:0]         thr_q;

  // divider
  logic                div_start, div_busy;
  logic [WideBits-1:0] div_num, div_quot;
  logic [TsBits-1:0]   div_den;

  fism_divider #(.NumBits(WideBits), .DenBits(TsBits)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .quot_o(div_quot)
  );

  logic [TsBits-1:0] diff_now;
  logic [TsBits-1:0] el_now;
  logic [TsBits-1:0] win_eff;
  assign diff_now = timestamp_ns_i - prev_q;
  assign win_eff = (win_q == '0) ? 64'd1 : {24'd0, win_q};

  assign fx = (frame_q > INTERVAL_BITS'(TMax >> 16)) || (INTERVAL_BITS > 40 &&
              ({{(TsBits-INTERVAL_BITS){1'b0}}, frame_q} > 64'(TMax >> 16)))
              ? TMax : TypBits'({{(TsBits-INTERVAL_BITS){1'b0}}, frame_q} << 16);
  assign rej_lim = (TypBits+4)'(rej_q) * (TypBits+4)'(typ_q);

  logic [COUNT_BITS-1:0] wf_inc;
  logic accept_in;
  assign accept_in = in_valid_i && in_ready_o;
  assign in_ready_o = (st_q == StIdle) && !out_valid_o;
  assign cfg_ready_o = 1'b1;

  logic [TsBits-1:0] wstart_eff;
  logic [COUNT_BITS-1:0] wf_base;
  always_comb begin
    wstart_eff = wstart_q ? wtime_q : timestamp_ns_i;
    wf_base = wstart_q ? wframes_q : '0;
    wf_inc = (wf_base < CMax) ? wf_base + 1'b1 : wf_base;
    el_now = timestamp_ns_i - wstart_eff;
  end

  always_comb begin
    div_start = 1'b0;
    div_num = '0;
    div_den = elapsed_q;
    case (st_q)
      StAvgGo: begin
        div_start = 1'b1;
        div_num = WideBits'(elapsed_q);
        div_den = TsBits'(wframes_q);
      end
      StFpsGo: begin
        div_start = 1'b1;
        div_num = WideBits'(wframes_q) * WideBits'(FpsScale);
        div_den = elapsed_q;
      end
      default: ;
    endcase
  end

  logic [63:0] rt;
  assign rt = 64'(acc_q >> 24);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WindowRst; abs_q <= '0; rel_q <= '0;
      gain_q <= GainRst; rej_q <= RejectRst;
      wstart_q <= 1'b0; have_prev_q <= 1'b0; wtime_q <= '0; prev_q <= '0;
      wframes_q <= '0; typ_q <= '0; cur_worst_q <= '0; cur_spk_q <= '0;
      last_worst_q <= '0; last_spk_q <= '0; last_avg_q <= '0; last_rate_q <= '0;
      now_q <= '0; valid_q <= 1'b0; frame_q <= '0; elapsed_q <= '0;
      closed_q <= 1'b0; thr_q <= '0; acc_q <= '0; mcand_q <= '0;
      coef_q <= '0; mcnt_q <= '0; neg_q <= 1'b0;
      st_q <= StIdle; out_valid_o <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegWindow: win_q  <= cfg_data_i;
          RegAbsThr: abs_q  <= cfg_data_i;
          RegRelFac: rel_q  <= cfg_data_i[15:0];
          RegGain:   gain_q <= cfg_data_i[15:0];
          RegReject: rej_q  <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      case (st_q)
        StIdle: if (accept_in) begin
          now_q <= timestamp_ns_i;
          valid_q <= have_prev_q;
          frame_q <= (diff_now > 64'(IMax)) ? IMax : INTERVAL_BITS'(diff_now);
          wstart_q <= 1'b1;
          wtime_q <= wstart_eff;
          wframes_q <= wf_inc;
          elapsed_q <= el_now;
          closed_q <= (el_now >= win_eff);
          have_prev_q <= 1'b1;
          prev_q <= timestamp_ns_i;
          st_q <= (el_now >= win_eff) ? StAvgGo : StPrep;
        end
        StAvgGo: st_q <= StAvgW;
        StAvgW: if (!div_busy) begin
          last_avg_q <= (div_quot > WideBits'(IMax)) ? IMax : INTERVAL_BITS'(div_quot);
          st_q <= StFpsGo;
        end
        StFpsGo: st_q <= StFpsW;
        StFpsW: if (!div_busy) begin
          last_rate_q <= (div_quot > WideBits'({RateBits{1'b1}})) ? '1
                         : RateBits'(div_quot);
          wtime_q <= now_q; wframes_q <= '0;
          last_worst_q <= cur_worst_q; last_spk_q <= cur_spk_q;
          cur_worst_q <= '0; cur_spk_q <= '0;
          st_q <= StPrep;
        end
        StPrep: begin
          if (!valid_q) begin
            frame_q <= '0; thr_q <= '0;
            st_q <= StFin;
          end else begin
            if (frame_q > cur_worst_q) cur_worst_q <= frame_q;
            st_q <= StEma;
          end
        end
        StEma: begin
          if (typ_q == '0) begin
            typ_q <= fx;
            st_q <= StRel;
          end else if ((TypBits+4)'({{(TsBits-INTERVAL_BITS){1'b0}}, frame_q}) <=
                       (rej_lim >> 16)) begin
            neg_q <= (fx < typ_q);
            mcand_q <= (TypBits+16)'((fx >= typ_q) ? fx - typ_q : typ_q - fx);
            coef_q <= gain_q; acc_q <= '0; mcnt_q <= 5'd16;
            st_q <= StEmaMul;
          end else begin
            st_q <= StRel;
          end
        end
        StEmaMul: begin
          if (mcnt_q != '0) begin
            if (coef_q[0]) acc_q <= acc_q + (TypBits+17)'(mcand_q);
            mcand_q <= mcand_q << 1; coef_q <= coef_q >> 1;
            mcnt_q <= mcnt_q - 1'b1;
          end else begin
            // floor(g*d/2^16) matches the split form exactly
            typ_q <= neg_q ? typ_q - TypBits'(acc_q >> 16)
                           : typ_q + TypBits'(acc_q >> 16);
            st_q <= StRel;
          end
        end
        StRel: begin
          thr_q <= 64'(abs_q);
          if (rel_q != '0 && typ_q != '0) begin
            mcand_q <= (TypBits+16)'(typ_q); coef_q <= rel_q;
            acc_q <= '0; mcnt_q <= 5'd16;
            st_q <= StRelMul;
          end else begin
            st_q <= StFin;
          end
        end
        StRelMul: begin
          if (mcnt_q != '0) begin
            if (coef_q[0]) acc_q <= acc_q + (TypBits+17)'(mcand_q);
            mcand_q <= mcand_q << 1; coef_q <= coef_q >> 1;
            mcnt_q <= mcnt_q - 1'b1;
          end else begin
            if (rt > thr_q) thr_q <= rt;
            st_q <= StFin;
          end
        end
        StFin: begin
          if (thr_q > 64'(IMax)) thr_q <= 64'(IMax);
          if (valid_q && thr_q != '0 && 64'(frame_q) > thr_q && cur_spk_q < CMax)
            cur_spk_q <= cur_spk_q + 1'b1;
          out_valid_o <= 1'b1;
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  logic [INTERVAL_BITS-1:0] thr_sat;
  logic spike_now;
  assign thr_sat = (thr_q > 64'(IMax)) ? IMax : INTERVAL_BITS'(thr_q);

  // result register, loaded in the final step
  always_ff @(posedge clk_i) begin
    if (st_q == StFin) begin
      interval_valid_o  <= valid_q;
      frame_ns_o        <= frame_q;
      spike_o           <= spike_now;
      threshold_ns_o    <= thr_sat;
      typical_ns_o      <= ((typ_q >> 16) > TypBits'(IMax)) ? IMax
                           : INTERVAL_BITS'(typ_q >> 16);
      window_closed_o   <= closed_q;
      avg_frame_ns_o    <= last_avg_q;
      fps_q8_o          <= last_rate_q;
      window_worst_ns_o <= last_worst_q;
      window_spikes_o   <= last_spk_q;
    end
  end
  assign spike_now = valid_q && (thr_sat != '0) && (frame_q > thr_sat);

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> !in_ready_o) else $error("accept while busy");
  a_div_go: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StAvgGo) |=> div_busy) else $error("divider not started");
  a_spike_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && spike_o) |-> interval_valid_o) else $error("spike without interval");
`endif
endmodule
